@@ rtl/kth_ancestor_binary_lifting_top_macros.svh @@
// Assertion macros shared by the k-th ancestor block.
// Each macro samples on clk and is disabled while arst_n is low.
`ifndef KTH_ANCESTOR_BINARY_LIFTING_TOP_MACROS_SVH
`define KTH_ANCESTOR_BINARY_LIFTING_TOP_MACROS_SVH

// Same-cycle implication.
`define KAL_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define KAL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ rtl/kal_pkg.sv @@
// Package for the k-th ancestor block: field widths, codes, sequencer states
// and the memory control struct. No dependencies.
package kal_pkg;

	localparam int NODE_W = 10;
	localparam int DIST_W = 16;
	localparam int CNT_W  = 11;

	localparam logic [CNT_W-1:0] NODE_COUNT_RESET = 11'd1024;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CLR_RD,
		ST_CLR_WR,
		ST_LIFT_RD,
		ST_LIFT_MID,
		ST_LIFT_WR,
		ST_Q_STEP,
		ST_Q_WAIT,
		ST_Q_DONE
	} kal_state_t;

	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} kal_mem_ctl_t;

endpackage

@@ rtl/kal_req_if.sv @@
// Request channel of the k-th ancestor block: load and query transactions.
// Depends on kal_pkg for field widths.
interface kal_req_if import kal_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              kind;
	logic [NODE_W-1:0] node;
	logic              has_parent;
	logic [NODE_W-1:0] parent_node;
	logic [DIST_W-1:0] distance;
	logic              last_entry;

	modport source (output valid, kind, node, has_parent, parent_node, distance, last_entry,
		input ready);
	modport sink (input valid, kind, node, has_parent, parent_node, distance, last_entry,
		output ready);
endinterface

@@ rtl/kal_rsp_if.sv @@
// Response channel of the k-th ancestor block: one transaction per query.
// Depends on kal_pkg for field widths.
interface kal_rsp_if import kal_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [NODE_W-1:0] ancestor;
	logic              found;

	modport source (output valid, ancestor, found, input ready);
	modport sink (input valid, ancestor, found, output ready);
endinterface

@@ rtl/kal_cfg_if.sv @@
// Configuration write channel of the k-th ancestor block (node count register).
// Depends on kal_pkg for the register width.
interface kal_cfg_if import kal_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CNT_W-1:0] node_count;

	modport source (output valid, node_count, input ready);
	modport sink (input valid, node_count, output ready);
endinterface

@@ rtl/kal_mem.sv @@
// Single write port, single registered read port memory for the lifting table.
// Depends on kal_pkg for the control struct.
module kal_mem import kal_pkg::*; #(
	parameter int DEPTH = 10240,
	parameter int AW    = 14,
	parameter int DW    = 11
) (
	input  logic          clk,
	input  kal_mem_ctl_t  ctl,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];
	logic [DW-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/kal_seq.sv @@
// Sequencer of the k-th ancestor block: table build and query walk over one table memory.
// Depends on kal_pkg, the channel interfaces and the assertion macro header.
`include "kth_ancestor_binary_lifting_top_macros.svh"

module kal_seq import kal_pkg::*; #(
	parameter int MAX_NODES = 1024,
	parameter int LEVELS    = 10,
	parameter int CW        = 11,
	parameter int AW        = 14,
	parameter int DW        = 11
) (
	input  logic          clk,
	input  logic          arst_n,
	kal_req_if.sink       req,
	kal_rsp_if.source     rsp,
	input  logic [CW-1:0] cnt,
	input  logic          cfg_wr,
	output kal_mem_ctl_t  mem_ctl,
	output logic [AW-1:0] mem_waddr,
	output logic [DW-1:0] mem_wdata,
	output logic [AW-1:0] mem_raddr,
	input  logic [DW-1:0] mem_rdata
);

	localparam int IDX_W = $clog2(MAX_NODES);
	localparam int PW    = DW - 1;
	localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
	localparam int QW    = $clog2(LEVELS + 1);

	kal_state_t state_q, state_d;

	logic [IDX_W-1:0]  i_q;
	logic [LW-1:0]     j_q;
	logic [QW-1:0]     lvl_q;
	logic [PW-1:0]     cur_q;
	logic [LEVELS-1:0] dist_q;
	logic              found_q;
	logic              table_ready_q;
	logic              rsp_valid_q;
	logic [NODE_W-1:0] rsp_anc_q;
	logic              rsp_found_q;

	logic          accept;
	logic          node_ok;
	logic          dist_ok;
	logic          query_ok;
	logic          last_node;
	logic          last_level;
	logic          lvl_end;
	logic          bit_set;
	logic          rd_valid;
	logic [PW-1:0] rd_idx;
	logic [PW-1:0] node_ext;
	logic          slot_free;
	logic          step_adv;
	logic          build_done;

	function automatic logic [AW-1:0] mem_addr(input logic [LW-1:0] lv,
		input logic [IDX_W-1:0] nd);
		return AW'({lv, nd});
	endfunction

	assign accept     = req.valid && req.ready;
	assign node_ok    = CW'(req.node) < cnt;
	assign dist_ok    = (32'(req.distance) >> LEVELS) == 32'd0;
	assign query_ok   = table_ready_q && node_ok && dist_ok;
	assign last_node  = CW'(i_q) == (cnt - CW'(1));
	assign last_level = j_q == LW'(LEVELS - 1);
	assign lvl_end    = lvl_q == QW'(LEVELS);
	assign bit_set    = dist_q[lvl_q[LW-1:0]];
	assign rd_valid   = mem_rdata[PW];
	assign rd_idx     = mem_rdata[PW-1:0];
	assign node_ext   = PW'(req.node);
	assign slot_free  = !rsp_valid_q || rsp.ready;
	assign step_adv   = (state_q == ST_LIFT_MID && !rd_valid) || state_q == ST_LIFT_WR;
	assign build_done = (state_q == ST_CLR_WR && last_node && LEVELS == 1)
		|| (step_adv && last_node && last_level);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.kind == KIND_LOAD) begin
						if (req.last_entry && cnt != CW'(0)) begin
							state_d = ST_CLR_RD;
						end
					end else if (query_ok) begin
						state_d = ST_Q_STEP;
					end else begin
						state_d = ST_Q_DONE;
					end
				end
			end
			ST_CLR_RD: state_d = ST_CLR_WR;
			ST_CLR_WR: begin
				if (last_node) begin
					state_d = (LEVELS > 1) ? ST_LIFT_RD : ST_IDLE;
				end else begin
					state_d = ST_CLR_RD;
				end
			end
			ST_LIFT_RD: state_d = ST_LIFT_MID;
			ST_LIFT_MID: begin
				if (rd_valid) begin
					state_d = ST_LIFT_WR;
				end else begin
					state_d = (last_node && last_level) ? ST_IDLE : ST_LIFT_RD;
				end
			end
			ST_LIFT_WR: state_d = (last_node && last_level) ? ST_IDLE : ST_LIFT_RD;
			ST_Q_STEP: begin
				priority if (lvl_end) begin
					state_d = ST_Q_DONE;
				end else if (bit_set) begin
					state_d = ST_Q_WAIT;
				end
			end
			ST_Q_WAIT: state_d = rd_valid ? ST_Q_STEP : ST_Q_DONE;
			ST_Q_DONE: begin
				if (slot_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		mem_ctl   = '0;
		mem_waddr = '0;
		mem_wdata = '0;
		mem_raddr = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && req.kind == KIND_LOAD && node_ok) begin
					mem_ctl.wr_en = 1'b1;
					mem_waddr     = mem_addr(LW'(0), node_ext[IDX_W-1:0]);
					mem_wdata     = {req.has_parent, PW'(req.parent_node)};
				end
			end
			ST_CLR_RD: begin
				mem_ctl.rd_en = 1'b1;
				mem_raddr     = mem_addr(LW'(0), i_q);
			end
			ST_CLR_WR: begin
				if (!rd_valid || CW'(rd_idx) >= cnt) begin
					mem_ctl.wr_en = 1'b1;
					mem_waddr     = mem_addr(LW'(0), i_q);
				end
			end
			ST_LIFT_RD: begin
				mem_ctl.rd_en = 1'b1;
				mem_raddr     = mem_addr(j_q - LW'(1), i_q);
			end
			ST_LIFT_MID: begin
				if (rd_valid) begin
					mem_ctl.rd_en = 1'b1;
					mem_raddr     = mem_addr(j_q - LW'(1), rd_idx[IDX_W-1:0]);
				end else begin
					mem_ctl.wr_en = 1'b1;
					mem_waddr     = mem_addr(j_q, i_q);
				end
			end
			ST_LIFT_WR: begin
				mem_ctl.wr_en = 1'b1;
				mem_waddr     = mem_addr(j_q, i_q);
				mem_wdata     = mem_rdata;
			end
			ST_Q_STEP: begin
				if (!lvl_end && bit_set) begin
					mem_ctl.rd_en = 1'b1;
					mem_raddr     = mem_addr(lvl_q[LW-1:0], cur_q[IDX_W-1:0]);
				end
			end
			ST_Q_WAIT, ST_Q_DONE: begin
				mem_ctl = '0;
			end
			default: mem_ctl = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			i_q           <= '0;
			j_q           <= '0;
			lvl_q         <= '0;
			found_q       <= 1'b0;
			table_ready_q <= 1'b0;
			rsp_valid_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			if (rsp_valid_q && rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
			if (state_q == ST_Q_DONE && slot_free) begin
				rsp_valid_q <= 1'b1;
			end
			if (cfg_wr) begin
				table_ready_q <= 1'b0;
			end
			if (accept && req.kind == KIND_LOAD) begin
				table_ready_q <= req.last_entry && cnt == CW'(0);
			end
			if (build_done) begin
				table_ready_q <= 1'b1;
			end
			if (accept) begin
				i_q     <= '0;
				j_q     <= LW'(1);
				lvl_q   <= '0;
				found_q <= query_ok;
			end
			if (state_q == ST_CLR_WR || step_adv) begin
				i_q <= last_node ? '0 : i_q + IDX_W'(1);
			end
			if (step_adv && last_node) begin
				j_q <= j_q + LW'(1);
			end
			if ((state_q == ST_Q_STEP && !lvl_end && !bit_set)
				|| (state_q == ST_Q_WAIT && rd_valid)) begin
				lvl_q <= lvl_q + QW'(1);
			end
			if (state_q == ST_Q_WAIT && !rd_valid) begin
				found_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cur_q  <= node_ext;
			dist_q <= req.distance[LEVELS-1:0];
		end
		if (state_q == ST_Q_WAIT && rd_valid) begin
			cur_q <= rd_idx;
		end
		if (state_q == ST_Q_DONE && slot_free) begin
			rsp_anc_q   <= found_q ? cur_q[NODE_W-1:0] : '0;
			rsp_found_q <= found_q;
		end
	end

	assign req.ready    = state_q == ST_IDLE;
	assign rsp.valid    = rsp_valid_q;
	assign rsp.ancestor = rsp_anc_q;
	assign rsp.found    = rsp_found_q;

	`KAL_ASSERT_IMPLIES(a_build_index_in_range, state_q == ST_CLR_RD || state_q == ST_CLR_WR || state_q == ST_LIFT_RD || state_q == ST_LIFT_MID || state_q == ST_LIFT_WR, CW'(i_q) < cnt, "build index beyond node count")
	`KAL_ASSERT_NEXT(a_load_clears_ready, accept && req.kind == KIND_LOAD && !req.last_entry, !table_ready_q, "table still ready after a load")
	`KAL_ASSERT_IMPLIES(a_found_needs_table, state_q == ST_Q_DONE && found_q, table_ready_q, "found result without a built table")
	`KAL_ASSERT_IMPLIES(a_no_write_in_query, state_q == ST_Q_STEP || state_q == ST_Q_WAIT || state_q == ST_Q_DONE, !mem_ctl.wr_en, "table written during a query")

endmodule

@@ rtl/kth_ancestor_binary_lifting_top.sv @@
// Top level of the k-th ancestor block: node count register, sequencer and table memory.
// Depends on kal_pkg, kal_req_if, kal_rsp_if, kal_cfg_if, kal_mem and kal_seq.
//
// Usage: the req channel carries load transactions (kind 0), which write one node's
// parent entry, and query transactions (kind 1), which ask for the distance-th ancestor
// of a node. The rsp channel returns one transaction per query with ancestor and found.
// The cfg channel writes node_count; the user writes it only while the block is idle,
// which the block itself does not enforce. A load with last_entry and a nonzero node
// count then builds the table: for level zero each node's entry is read and cleared if
// its parent is invalid or not below the node count; for each further level the node's
// entry one level down is followed and the entry it points to is copied up, or an invalid
// entry is written. A query reads the table at most once per set bit of its distance.
// req.ready is high only while the sequencer is idle. A finished result waits in the
// output register while rsp.ready is low; the next transaction is still accepted, and a
// second result waits in the sequencer until the register frees.
// Reset clears the table-ready flag and sets node_count to 1024; the table memory is
// not cleared: the user loads every node in use before the build; the block does not check.
module kth_ancestor_binary_lifting_top import kal_pkg::*; #(
	parameter int MAX_NODES = 1024,
	parameter int LEVELS    = 10
) (
	input  logic      clk,
	input  logic      arst_n,
	kal_cfg_if.sink   cfg,
	kal_req_if.sink   req,
	kal_rsp_if.source rsp
);

	localparam int IDX_W  = $clog2(MAX_NODES);
	localparam int PW     = (IDX_W > NODE_W) ? IDX_W : NODE_W;
	localparam int CW_RAW = $clog2(MAX_NODES + 1);
	localparam int CW     = (CW_RAW > CNT_W) ? CW_RAW : CNT_W;
	localparam int DW     = PW + 1;
	localparam int DEPTH  = LEVELS * (2 ** IDX_W);
	localparam int AW     = $clog2(DEPTH);

	logic [CNT_W-1:0] node_count_q;
	logic [CW-1:0]    cnt;
	logic             cfg_wr;

	kal_mem_ctl_t  mem_ctl;
	logic [AW-1:0] mem_waddr;
	logic [DW-1:0] mem_wdata;
	logic [AW-1:0] mem_raddr;
	logic [DW-1:0] mem_rdata;

	assign cfg.ready = 1'b1;
	assign cfg_wr    = cfg.valid && cfg.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODE_COUNT_RESET;
		end else if (cfg_wr) begin
			node_count_q <= cfg.node_count;
		end
	end

	assign cnt = (CW'(node_count_q) < CW'(MAX_NODES)) ? CW'(node_count_q) : CW'(MAX_NODES);

	kal_mem #(
		.DEPTH (DEPTH),
		.AW    (AW),
		.DW    (DW)
	) u_mem (
		.clk   (clk),
		.ctl   (mem_ctl),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	kal_seq #(
		.MAX_NODES (MAX_NODES),
		.LEVELS    (LEVELS),
		.CW        (CW),
		.AW        (AW),
		.DW        (DW)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp       (rsp),
		.cnt       (cnt),
		.cfg_wr    (cfg_wr),
		.mem_ctl   (mem_ctl),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

endmodule

@@ tb/sv/kth_ancestor_binary_lifting_top_test.sv @@
// Self-checking testbench for kth_ancestor_binary_lifting_top: loads random forests,
// builds the lifting table and checks every query against a predictor or a fixed answer.
// Depends on kal_pkg, kal_cfg_if, kal_req_if, kal_rsp_if and the block's RTL.
module kth_ancestor_binary_lifting_top_test;
	import kal_pkg::*;

	localparam int TREE_NODES  = 1024;
	localparam int LIFT_LEVELS = 10;

	typedef enum logic [1:0] {
		OP_CFG,
		OP_LOAD,
		OP_QUERY
	} drill_op_t;

	typedef enum int {
		PACE_STEADY,
		PACE_SENDER_GAPS,
		PACE_RECEIVER_STALLS,
		PACE_BOTH
	} pace_t;

	typedef struct packed {
		logic              kind;
		logic [NODE_W-1:0] node;
		logic              has_parent;
		logic [NODE_W-1:0] parent_node;
		logic [DIST_W-1:0] distance;
		logic              last_entry;
	} request_t;

	typedef struct packed {
		logic [NODE_W-1:0] ancestor;
		logic              found;
	} answer_t;

	typedef struct packed {
		logic              valid;
		logic [NODE_W-1:0] idx;
	} hop_t;

	typedef struct packed {
		drill_op_t         op;
		logic [CNT_W-1:0]  count;
		logic [NODE_W-1:0] node;
		logic              has_parent;
		logic [NODE_W-1:0] parent_node;
		logic [DIST_W-1:0] distance;
		logic              last_entry;
		logic              pinned;
		logic              found;
		logic [NODE_W-1:0] ancestor;
	} drill_row_t;

	drill_row_t drill_plan [28] = '{
		'{OP_QUERY, 11'd0, 10'd0,    1'b0, 10'd0,   16'd0,    1'b0, 1'b1, 1'b0, 10'd0},
		'{OP_QUERY, 11'd0, 10'd1023, 1'b0, 10'd0,   16'hFFFF, 1'b0, 1'b1, 1'b0, 10'd0},
		'{OP_CFG,   11'd4, 10'd0,    1'b0, 10'd0,   16'd0,    1'b0, 1'b0, 1'b0, 10'd0},
		'{OP_LOAD,  11'd0, 10'd0,    1'b0, 10'd0,   16'd0,    1'b0, 1'b0, 1'b0, 10'd0},
		'{OP_LOAD,  11'd0, 10'd1,    1'b1, 10'd0,   16'd0,    1'b0, 1'b0, 1'b0, 10'd0},
		'{OP_LOAD,  11'd0, 10'd2,    1'b1, 10'd1,   16'd0,    1'b0, 1'b0, 1'b0, 10'd0},
		'{OP_LOAD,  11'd0, 10'd3,    1'b1, 10'd2,   16'd0,    1'b1, 1'b0, 1'b0, 10'd0},
		'{OP_QUERY, 11'd0, 10'd3,    1'b0, 10'd0,   16'd0,    1'b0, 1'b1, 1'b1, 10'd3},
		'{OP_QUERY, 11'd0, 10'd3,    1'b0, 10'd0,   16'd3,    1'b0, 1'b1, 1'b1, 10'd0},
		'{OP_QUERY, 11'd0, 10'd3,    1'b0, 10'd0,   16'd4,    1'b0, 1'b1, 1'b0, 10'd0},
		'{OP_QUERY, 11'd0, 10'd4,    1'b0, 10'd0,   16'd0,    1'b0, 1'b1, 1'b0, 10'd0},
		'{OP_QUERY, 11'd0, 10'd3,    1'b0, 10'd0,   16'd1024, 1'b0, 1'b1, 1'b0, 10'd0},
		'{OP_LOAD,  11'd0, 10'd1023, 1'b1, 10'd5,   16'd0,    1'b1, 1'b0, 1'b0, 10'd0},
		'{OP_QUERY, 11'd0, 10'd2,    1'b0, 10'd0,   16'd2,    1'b0, 1'b1, 1'b1, 10'd0},
		'{OP_LOAD,  11'd0, 10'd1,    1'b1, 10'd900, 16'd0,    1'b0, 1'b0, 1'b0, 10'd0},
		'{OP_QUERY, 11'd0, 10'd3,    1'b0, 10'd0,   16'd1,    1'b0, 1'b1, 1'b0, 10'd0},
		'{OP_LOAD,  11'd0, 10'd0,    1'b1, 10'd0,   16'd0,    1'b1, 1'b0, 1'b0, 10'd0},
		'{OP_QUERY, 11'd0, 10'd3,    1'b0, 10'd0,   16'd1023, 1'b0, 1'b0, 1'b0, 10'd0},
		'{OP_QUERY, 11'd0, 10'd0,    1'b0, 10'd0,   16'd1023, 1'b0, 1'b0, 1'b0, 10'd0},
		'{OP_QUERY, 11'd0, 10'd3,    1'b0, 10'd0,   16'd2,    1'b0, 1'b0, 1'b0, 10'd0},
		'{OP_CFG,   11'd1, 10'd0,    1'b0, 10'd0,   16'd0,    1'b0, 1'b0, 1'b0, 10'd0},
		'{OP_QUERY, 11'd0, 10'd0,    1'b0, 10'd0,   16'd0,    1'b0, 1'b1, 1'b0, 10'd0},
		'{OP_LOAD,  11'd0, 10'd0,    1'b0, 10'd0,   16'd0,    1'b1, 1'b0, 1'b0, 10'd0},
		'{OP_QUERY, 11'd0, 10'd0,    1'b0, 10'd0,   16'd0,    1'b0, 1'b1, 1'b1, 10'd0},
		'{OP_QUERY, 11'd0, 10'd0,    1'b0, 10'd0,   16'd1,    1'b0, 1'b1, 1'b0, 10'd0},
		'{OP_CFG,   11'd0, 10'd0,    1'b0, 10'd0,   16'd0,    1'b0, 1'b0, 1'b0, 10'd0},
		'{OP_LOAD,  11'd0, 10'd0,    1'b1, 10'd1,   16'd0,    1'b1, 1'b0, 1'b0, 10'd0},
		'{OP_QUERY, 11'd0, 10'd0,    1'b0, 10'd0,   16'd0,    1'b0, 1'b1, 1'b0, 10'd0}
	};

	logic clk;
	logic arst_n;

	kal_cfg_if cfg_ch ();
	kal_req_if req_ch ();
	kal_rsp_if rsp_ch ();

	kth_ancestor_binary_lifting_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_ch),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	hop_t             hops [TREE_NODES][LIFT_LEVELS];
	bit               loaded_once [TREE_NODES];
	logic [CNT_W-1:0] count_reg;
	bit               lift_ready;
	answer_t          pending_answers [$];
	pace_t            pace;
	int               accepted_items;
	int               mismatches;

	initial begin
		clk = 1'b0;
	end

	always #10 clk = ~clk;

	initial begin
		#20000000;
		$display("kth_ancestor_binary_lifting_top: mismatch");
		$finish;
	end

	function automatic int node_limit();
		return (int'(count_reg) < TREE_NODES) ? int'(count_reg) : TREE_NODES;
	endfunction

	function automatic bit tree_complete(int n);
		for (int i = 0; i < n; i++) begin
			if (!loaded_once[i]) begin
				return 1'b0;
			end
		end
		return 1'b1;
	endfunction

	function automatic void build_lifting();
		int   n;
		hop_t mid;
		n = node_limit();
		for (int i = 0; i < n; i++) begin
			if (!hops[i][0].valid || int'(hops[i][0].idx) >= n) begin
				hops[i][0] = '0;
			end
		end
		for (int j = 1; j < LIFT_LEVELS; j++) begin
			for (int i = 0; i < n; i++) begin
				mid = hops[i][j-1];
				hops[i][j] = mid.valid ? hops[mid.idx][j-1] : '0;
			end
		end
		lift_ready = 1'b1;
	endfunction

	function automatic answer_t walk_ancestor(logic [NODE_W-1:0] start, logic [DIST_W-1:0] k);
		answer_t           a;
		logic [NODE_W-1:0] cur;
		bit                ok;
		cur = start;
		ok = 1'b0;
		if (lift_ready && int'(start) < node_limit() && int'(k) < (1 << LIFT_LEVELS)) begin
			ok = 1'b1;
			for (int j = 0; j < LIFT_LEVELS && ok; j++) begin
				if (k[j]) begin
					if (hops[cur][j].valid) begin
						cur = hops[cur][j].idx;
					end else begin
						ok = 1'b0;
					end
				end
			end
		end
		a.found = ok;
		a.ancestor = ok ? cur : '0;
		return a;
	endfunction

	function automatic request_t query_item(int eff);
		request_t q;
		int       r;
		q.kind = KIND_QUERY;
		q.has_parent = 1'($urandom);
		q.parent_node = NODE_W'($urandom);
		q.last_entry = 1'($urandom);
		if (eff > 0 && $urandom_range(99) < 85) begin
			q.node = NODE_W'($urandom_range(eff - 1));
		end else begin
			q.node = NODE_W'($urandom);
		end
		r = $urandom_range(99);
		if (r < 40) begin
			q.distance = DIST_W'($urandom_range((eff + 2 > 1023) ? 1023 : eff + 2));
		end else if (r < 65) begin
			q.distance = DIST_W'($urandom_range(1023));
		end else if (r < 78) begin
			q.distance = DIST_W'(1 << $urandom_range(LIFT_LEVELS - 1));
		end else if (r < 90) begin
			q.distance = DIST_W'($urandom);
		end else begin
			case ($urandom_range(2))
				0: q.distance = '0;
				1: q.distance = DIST_W'(1023);
				default: q.distance = '1;
			endcase
		end
		return q;
	endfunction

	// Called just after a falling edge; returns just after the falling edge that
	// follows the accepting rising edge, with valid still high.
	task automatic send_request(input request_t r, input bit pinned, input answer_t typed);
		while ($urandom_range(99) < ((pace == PACE_SENDER_GAPS) ? 59 :
				(pace == PACE_BOTH) ? 9 : 0)) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind <= r.kind;
		req_ch.node <= r.node;
		req_ch.has_parent <= r.has_parent;
		req_ch.parent_node <= r.parent_node;
		req_ch.distance <= r.distance;
		req_ch.last_entry <= r.last_entry;
		do @(posedge clk); while (!req_ch.ready);
		accepted_items++;
		if (r.kind == KIND_LOAD) begin
			if (int'(r.node) < node_limit()) begin
				hops[r.node][0] = r.has_parent ? {1'b1, r.parent_node} : '0;
				loaded_once[r.node] = 1'b1;
			end
			lift_ready = 1'b0;
			if (r.last_entry) begin
				build_lifting();
			end
		end else begin
			pending_answers.push_back(pinned ? typed : walk_ancestor(r.node, r.distance));
		end
		@(negedge clk);
	endtask

	// The register is written only once all answers are in and any build has had
	// time to finish.
	task automatic write_node_count(input logic [CNT_W-1:0] value);
		int settle;
		req_ch.valid <= 1'b0;
		while (pending_answers.size() != 0) @(negedge clk);
		settle = 3 * LIFT_LEVELS * node_limit() + 4 * LIFT_LEVELS + 16;
		repeat (settle) @(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.node_count <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		count_reg = value;
		lift_ready = 1'b0;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic load_tree(input int eff);
		int       order [];
		int       j;
		int       t;
		int       r;
		request_t item;
		if (eff == 0) begin
			item.kind = KIND_LOAD;
			item.node = NODE_W'($urandom);
			item.has_parent = 1'($urandom);
			item.parent_node = NODE_W'($urandom);
			item.distance = DIST_W'($urandom);
			item.last_entry = 1'b1;
			send_request(item, 1'b0, '0);
		end else begin
			order = new[eff];
			for (int i = 0; i < eff; i++) begin
				order[i] = i;
			end
			for (int i = eff - 1; i > 0; i--) begin
				j = $urandom_range(i);
				t = order[i];
				order[i] = order[j];
				order[j] = t;
			end
			for (int i = 0; i < eff; i++) begin
				if ($urandom_range(99) < 8) begin
					if (eff < TREE_NODES && $urandom_range(1) == 1) begin
						item.kind = KIND_LOAD;
						item.node = NODE_W'($urandom_range(TREE_NODES - 1, eff));
						item.has_parent = 1'($urandom);
						item.parent_node = NODE_W'($urandom);
						item.distance = DIST_W'($urandom);
						item.last_entry = 1'b0;
					end else begin
						item = query_item(eff);
					end
					send_request(item, 1'b0, '0);
				end
				r = $urandom_range(99);
				item.kind = KIND_LOAD;
				item.node = NODE_W'(order[i]);
				item.distance = DIST_W'($urandom);
				item.has_parent = 1'b1;
				if (i == 0 || r >= 97) begin
					item.has_parent = 1'b0;
					item.parent_node = NODE_W'($urandom);
				end else if (r < 70) begin
					item.parent_node = NODE_W'(order[i-1]);
				end else if (r < 88) begin
					item.parent_node = NODE_W'(order[$urandom_range(i - 1)]);
				end else begin
					item.parent_node = NODE_W'($urandom);
				end
				item.last_entry = (i == eff - 1) ||
					($urandom_range(99) < 3 && tree_complete(eff));
				send_request(item, 1'b0, '0);
			end
		end
	endtask

	task automatic reload_some(input int eff);
		int       n;
		request_t item;
		n = $urandom_range(4, 1);
		for (int k = 0; k < n; k++) begin
			item.kind = KIND_LOAD;
			item.node = (eff > 0) ? NODE_W'($urandom_range(eff - 1)) : NODE_W'($urandom);
			item.has_parent = ($urandom_range(99) < 85);
			item.parent_node = (eff > 0 && $urandom_range(99) < 80) ?
				NODE_W'($urandom_range(eff - 1)) : NODE_W'($urandom);
			item.distance = DIST_W'($urandom);
			item.last_entry = (k == n - 1);
			send_request(item, 1'b0, '0);
		end
	endtask

	task automatic run_phase(input logic [CNT_W-1:0] count);
		int eff;
		int nq;
		write_node_count(count);
		eff = node_limit();
		if (eff < TREE_NODES || !tree_complete(eff)) begin
			load_tree(eff);
		end else begin
			reload_some(eff);
		end
		nq = (eff >= 40) ? 60 : $urandom_range(2 * eff + 16, eff + 8);
		repeat (nq) send_request(query_item(eff), 1'b0, '0);
		reload_some(eff);
		repeat (nq / 2) send_request(query_item(eff), 1'b0, '0);
	endtask

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= ((pace == PACE_RECEIVER_STALLS) ? 59 :
			(pace == PACE_BOTH) ? 9 : 0));
	end

	always @(posedge clk) begin
		answer_t want;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_answers.size() == 0) begin
				$error("unexpected response transaction: ancestor %0d, found %0d",
					rsp_ch.ancestor, rsp_ch.found);
				mismatches++;
			end else begin
				want = pending_answers.pop_front();
				if (rsp_ch.ancestor !== want.ancestor) begin
					$error("ancestor: expected %0d, actual %0d", want.ancestor, rsp_ch.ancestor);
					mismatches++;
				end
				if (rsp_ch.found !== want.found) begin
					$error("found: expected %0d, actual %0d", want.found, rsp_ch.found);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int               phase;
		int               base;
		int               settle;
		logic [CNT_W-1:0] count;
		drill_row_t       row;
		request_t         item;
		answer_t          typed;
		arst_n = 1'b0;
		cfg_ch.valid = 1'b0;
		cfg_ch.node_count = '0;
		req_ch.valid = 1'b0;
		req_ch.kind = KIND_LOAD;
		req_ch.node = '0;
		req_ch.has_parent = 1'b0;
		req_ch.parent_node = '0;
		req_ch.distance = '0;
		req_ch.last_entry = 1'b0;
		rsp_ch.ready = 1'b0;
		pace = PACE_STEADY;
		accepted_items = 0;
		mismatches = 0;
		count_reg = NODE_COUNT_RESET;
		lift_ready = 1'b0;
		for (int i = 0; i < TREE_NODES; i++) begin
			loaded_once[i] = 1'b0;
			for (int j = 0; j < LIFT_LEVELS; j++) begin
				hops[i][j] = '0;
			end
		end
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < $size(drill_plan); i++) begin
			row = drill_plan[i];
			item.kind = (row.op == OP_QUERY) ? KIND_QUERY : KIND_LOAD;
			item.node = row.node;
			item.has_parent = row.has_parent;
			item.parent_node = row.parent_node;
			item.distance = row.distance;
			item.last_entry = row.last_entry;
			typed.ancestor = row.ancestor;
			typed.found = row.found;
			if (row.op == OP_CFG) begin
				write_node_count(row.count);
			end else begin
				send_request(item, row.pinned, typed);
			end
		end

		base = accepted_items;
		phase = 0;
		while (accepted_items - base < 1300 || phase < 10) begin
			pace = pace_t'(phase % 4);
			case (phase)
				1: count = 11'd1024;
				3: count = 11'd2047;
				5: count = 11'd0;
				7: count = 11'd1025;
				default: count = ($urandom_range(99) < 15) ? CNT_W'($urandom_range(3, 1)) :
					CNT_W'($urandom_range(48, 4));
			endcase
			run_phase(count);
			phase++;
		end

		req_ch.valid <= 1'b0;
		while (pending_answers.size() != 0) @(negedge clk);
		settle = 3 * LIFT_LEVELS * node_limit() + 4 * LIFT_LEVELS + 16;
		repeat (settle) @(negedge clk);
		if (mismatches == 0) begin
			$display("kth_ancestor_binary_lifting_top: match");
		end else begin
			$display("kth_ancestor_binary_lifting_top: mismatch");
		end
		$finish;
	end

endmodule
